>>> rtl/box_filter_3x3_mean_assert.svh
// Assertion macros used by the box filter RTL.
`ifndef BOX_FILTER_3X3_MEAN_ASSERT_SVH
`define BOX_FILTER_3X3_MEAN_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset
`define BF3M_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box filter assertion failed");

// Next-cycle implication
`define BF3M_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box filter assertion failed");

`else

`define BF3M_ASSERT_IMP(label, clk, rst, ante, cons)
`define BF3M_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/bf3m_pkg.sv
// Package: constants and register codes for the 3x3 box filter.
`timescale 1ns / 1ps

package bf3m_pkg;

   // Default line store depth
   localparam int DEFAULT_MAX_LINE_WIDTH = 1024;

   // Field widths
   localparam int PIX_W   = 8;
   localparam int WIDTH_W = 11;
   localparam int HEIGHT_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int SUM_W = 12;   // nine 8-bit samples sum to at most 2295

   // Register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Register reset values
   localparam logic [WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd64;
   localparam logic [HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 16'd64;

   // Divide by nine: floor(s * 7282 / 65536) is exact for s below 2296
   localparam int RECIP_W = 13;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
   localparam int RECIP_SHIFT = 16;

endpackage

>>> rtl/bf3m_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module bf3m_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/box_filter_3x3_mean.sv
// 3x3 box mean filter over a raster-order 8-bit frame, interior pixels only.
// Pipeline: a window's last pixel is held in stage 1, its sum in stage 2, its mean in the output register.
// Throughput: one pixel per cycle while rsp_ready allows, set by the one line RAM read-modify-write per pixel.
// The line RAM holds both stored rows in one 16-bit word, read at acceptance, written as the pixel leaves stage 1.
// Reset: synchronous; clears counters, window, pipeline valids and restores the registers.
// The line RAM is not cleared; a stored row is written before it reaches a mean unless widened mid-frame.
`timescale 1ns / 1ps

`include "box_filter_3x3_mean_assert.svh"

module box_filter_3x3_mean #(
   parameter int MAX_LINE_WIDTH = bf3m_pkg::DEFAULT_MAX_LINE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bf3m_pkg::PIX_W-1:0]       req_pixel_value,
   // mean output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bf3m_pkg::PIX_W-1:0]       rsp_mean_value,
   output logic                             rsp_last_of_frame,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [bf3m_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import bf3m_pkg::*;

   localparam int XW = $clog2(MAX_LINE_WIDTH);
   localparam int PRODUCT_W = SUM_W + RECIP_W;

   // Registers
   logic [WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_W-1:0] frame_height_ff, frame_height_in;

   // Raster position of the next pixel
   logic [XW-1:0]       col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;

   // Stage 1: pixel waiting for its line RAM word
   logic                s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]    s1_pix_ff, s1_pix_in;
   logic [XW-1:0]       s1_idx_ff, s1_idx_in;
   logic                s1_emit_ff, s1_emit_in;
   logic                s1_last_ff, s1_last_in;

   // Stage 2: window sum
   logic                s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0]    s2_sum_ff, s2_sum_in;
   logic                s2_last_ff, s2_last_in;

   // Output word
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_mean_ff, rsp_mean_in;
   logic                rsp_last_ff, rsp_last_in;

   // Two previous window columns: 0..2 newest, 3..5 older
   logic [PIX_W-1:0]    win_ff [6];
   logic [PIX_W-1:0]    win_in [6];

   logic [XW-1:0]       last_col;
   logic [HEIGHT_W-1:0] last_row;
   logic                accept;
   logic                out_ready, s2_ready, s2_go, s1_go, s2_load;
   logic                ram_we, ram_re;
   logic [XW-1:0]       ram_waddr, ram_raddr;
   logic [2*PIX_W-1:0]  ram_wdata, ram_rdata;
   logic [PIX_W-1:0]    up_pix, mid_pix;
   logic [PRODUCT_W-1:0] product;

   // Clamp the registers to legal frame limits
   always_comb begin
      if (frame_width_ff < 11'd3) begin
         last_col = XW'(2);
      end else if (32'(frame_width_ff) > 32'(MAX_LINE_WIDTH)) begin
         last_col = XW'(MAX_LINE_WIDTH - 1);
      end else begin
         last_col = XW'(frame_width_ff - 11'd1);
      end
      if (frame_height_ff < 16'd3) begin
         last_row = 16'd2;
      end else begin
         last_row = frame_height_ff - 16'd1;
      end
   end

   // Handshake chain; non-emitting pixels leave stage 1 without a slot in stage 2
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s2_go     = s2_valid_ff && out_ready;
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || s2_ready);
   assign s2_load   = s1_go && s1_emit_ff;
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Line RAM: read at acceptance, rows shift down on write-back
   assign ram_re    = accept;
   assign ram_raddr = col_ff;
   assign ram_we    = s1_go;
   assign ram_waddr = s1_idx_ff;
   assign up_pix    = ram_rdata[2*PIX_W-1:PIX_W];
   assign mid_pix   = ram_rdata[PIX_W-1:0];
   assign ram_wdata = {mid_pix, s1_pix_ff};

   bf3m_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Register writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata[WIDTH_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Raster counters and stage 1 capture
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      s1_pix_in   = s1_pix_ff;
      s1_idx_in   = s1_idx_ff;
      s1_emit_in  = s1_emit_ff;
      s1_last_in  = s1_last_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pix_in   = req_pixel_value;
         s1_idx_in   = col_ff;
         s1_emit_in  = (col_ff >= XW'(2)) && (row_ff >= 16'd2);
         s1_last_in  = (col_ff >= last_col) && (row_ff >= last_row);
         if (col_ff >= last_col) begin
            col_in = '0;
            row_in = (row_ff >= last_row) ? '0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   // Window shift and nine-sample sum
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         win_in[k] = win_ff[k];
      end
      if (s1_go) begin
         win_in[3] = win_ff[0];
         win_in[4] = win_ff[1];
         win_in[5] = win_ff[2];
         win_in[0] = up_pix;
         win_in[1] = mid_pix;
         win_in[2] = s1_pix_ff;
      end
      s2_sum_in = SUM_W'(up_pix) + SUM_W'(mid_pix) + SUM_W'(s1_pix_ff)
                + SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2])
                + SUM_W'(win_ff[3]) + SUM_W'(win_ff[4]) + SUM_W'(win_ff[5]);
      s2_last_in  = s1_last_ff;
      s2_valid_in = s2_load ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
   end

   // Divide by nine through the reciprocal
   assign product = PRODUCT_W'(s2_sum_ff) * PRODUCT_W'(DIV9_RECIP);

   always_comb begin
      rsp_mean_in  = product[RECIP_SHIFT +: PIX_W];
      rsp_last_in  = s2_last_ff;
      rsp_valid_in = s2_go ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s1_pix_ff  <= s1_pix_in;
      s1_idx_ff  <= s1_idx_in;
      s1_emit_ff <= s1_emit_in;
      s1_last_ff <= s1_last_in;
      if (s2_load) begin
         s2_sum_ff  <= s2_sum_in;
         s2_last_ff <= s2_last_in;
      end
      if (s2_go) begin
         rsp_mean_ff <= rsp_mean_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_value    = rsp_mean_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // Checks
   `BF3M_ASSERT_IMP(a_ram_no_collision, clock, reset, ram_we && ram_re, ram_waddr != ram_raddr)
   `BF3M_ASSERT_NXT(a_accept_fills_s1, clock, reset, accept, s1_valid_ff)
   `BF3M_ASSERT_IMP(a_rsp_from_s2, clock, reset, $rose(rsp_valid_ff), $past(s2_valid_ff))
   `BF3M_ASSERT_NXT(a_s1_stall_holds_ram, clock, reset, s1_valid_ff && !s1_go, $stable(ram_rdata))

endmodule

>>> test/tb_box_filter_3x3_mean.sv
// Testbench for the 3x3 box mean filter: streamed frames checked against a cycle-free predictor.
`timescale 1ns / 1ps

module tb_box_filter_3x3_mean;
   import bf3m_pkg::*;

   localparam int LINE_MAX = DEFAULT_MAX_LINE_WIDTH;
   localparam int SETTLE_CYCLES = 8;   // comfortably past the stage 1, stage 2 and output registers

   typedef struct packed {
      logic [PIX_W-1:0] mean;
      logic             last;
   } mean_word_type;

   typedef enum int {
      PIX_RANDOM,
      PIX_ALL_HIGH,
      PIX_ALL_LOW,
      PIX_TWO_LEVEL,
      PIX_NEAR_EXTREME
   } pix_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_mean_value;
   logic                  rsp_last_of_frame;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: line stores, window, raster position and registers
   logic [PIX_W-1:0]    upper_row [LINE_MAX];
   logic [PIX_W-1:0]    middle_row [LINE_MAX];
   logic [PIX_W-1:0]    window_px [6];
   int                  col_cnt = 0;
   int                  row_cnt = 0;
   logic [WIDTH_W-1:0]  width_reg = RESET_FRAME_WIDTH;
   logic [HEIGHT_W-1:0] height_reg = RESET_FRAME_HEIGHT;

   mean_word_type expected_means [$];
   int            errors = 0;
   int            pixels_sent = 0;
   pix_mode_type  pix_mode = PIX_RANDOM;
   bit            steady_sender = 1'b0;
   bit            steady_receiver = 1'b0;
   int            rsp_hold = 0;

   box_filter_3x3_mean u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Register values as the filter applies them
   function automatic int width_in_use();
      int w = width_reg;
      if (w < 3) w = 3;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
   endfunction

   function automatic int height_in_use();
      int h = height_reg;
      if (h < 3) h = 3;
      return h;
   endfunction

   // Advance the predictor by one pixel; queue a mean once the window is full
   task automatic predict_mean(input logic [PIX_W-1:0] pix);
      int         w;
      int         h;
      int         idx;
      int         total;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      mean_word_type word;
      w = width_in_use();
      h = height_in_use();
      idx = (col_cnt < LINE_MAX) ? col_cnt : LINE_MAX - 1;
      up = upper_row[idx];
      mid = middle_row[idx];
      if (col_cnt >= 2 && row_cnt >= 2) begin
         total = up + mid + pix;
         foreach (window_px[k]) total += window_px[k];
         word.mean = PIX_W'(total / 9);
         word.last = (col_cnt >= w - 1) && (row_cnt >= h - 1);
         expected_means.push_back(word);
      end
      // rows shift down at this column
      upper_row[idx] = mid;
      middle_row[idx] = pix;
      // older column to slots 3..5, newest to 0..2
      window_px[3] = window_px[0];
      window_px[4] = window_px[1];
      window_px[5] = window_px[2];
      window_px[0] = up;
      window_px[1] = mid;
      window_px[2] = pix;
      // raster position; a counter past a narrowed range closes on this pixel
      if (col_cnt >= w - 1) begin
         col_cnt = 0;
         row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
      end else begin
         col_cnt++;
      end
   endtask

   function automatic logic [PIX_W-1:0] next_pixel();
      case (pix_mode)
         PIX_ALL_HIGH: return {PIX_W{1'b1}};
         PIX_ALL_LOW: return {PIX_W{1'b0}};
         PIX_TWO_LEVEL: return $urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
         PIX_NEAR_EXTREME: begin
            if ($urandom_range(0, 1)) return PIX_W'($urandom_range(250, 255));
            return PIX_W'($urandom_range(0, 5));
         end
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // One pixel word; valid stays up across back-to-back words
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      predict_mean(pix);
      pixels_sent++;
   endtask

   task automatic run_to_frame_end();
      do send_pixel(next_pixel()); while (col_cnt != 0 || row_cnt != 0);
   endtask

   // Stop the stream and wait until every mean has come out
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_FRAME_WIDTH) width_reg = data[WIDTH_W-1:0];
      else height_reg = data[HEIGHT_W-1:0];
   endtask

   // Register writes only ever happen with the filter drained
   task automatic set_regs(input bit do_w, input logic [CSR_DATA_W-1:0] w_word,
                           input bit do_h, input logic [CSR_DATA_W-1:0] h_word);
      settle();
      if (do_w) write_reg(REG_FRAME_WIDTH, w_word);
      if (do_h) write_reg(REG_FRAME_HEIGHT, h_word);
      csr_valid <= 1'b0;
   endtask

   // Reset sizes: three full rows of 64, then cut the height so the next row ends the frame
   task automatic test_reset_defaults();
      pix_mode = PIX_RANDOM;
      repeat (3 * width_in_use()) send_pixel(next_pixel());
      set_regs(1'b0, '0, 1'b1, 16'd3);
      run_to_frame_end();
   endtask

   // Smallest frames with saturated, empty and bit-pattern content; clamped sizes
   task automatic test_extreme_pixels();
      logic [PIX_W-1:0] pattern [9] = '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55,
                                        8'hAA, 8'h0F, 8'hF0, 8'hFF};
      set_regs(1'b1, 16'd3, 1'b1, 16'd3);
      repeat (9) send_pixel({PIX_W{1'b1}});
      repeat (9) send_pixel({PIX_W{1'b0}});
      // width 0 under ignored upper bits, height 1: both act as 3
      set_regs(1'b1, 16'hF800, 1'b1, 16'd1);
      foreach (pattern[k]) send_pixel(pattern[k]);
   endtask

   // Oversized width clamps to the full line store, height 2 clamps to 3
   task automatic test_widest_frame();
      pix_mode = PIX_RANDOM;
      set_regs(1'b1, 16'h07FF, 1'b1, 16'd2);
      run_to_frame_end();
   endtask

   // Sizes changed part-way through a frame
   task automatic test_mid_frame_changes();
      pix_mode = PIX_RANDOM;
      // tallest height, then lowered so the current row is the last
      set_regs(1'b1, 16'd5, 1'b1, 16'hFFFF);
      repeat (30) send_pixel(next_pixel());
      set_regs(1'b0, '0, 1'b1, 16'd7);
      run_to_frame_end();
      // width narrowed with the column already past the new end
      set_regs(1'b1, 16'd12, 1'b1, 16'd5);
      repeat (31) send_pixel(next_pixel());
      set_regs(1'b1, 16'd4, 1'b0, '0);
      run_to_frame_end();
      // exact full width, narrowed to the minimum during the first row
      set_regs(1'b1, 16'd1024, 1'b1, 16'd3);
      repeat (5) send_pixel(next_pixel());
      set_regs(1'b1, 16'd3, 1'b0, '0);
      run_to_frame_end();
   endtask

   // Random small frames; some cut short for a size change, widening only between frames
   task automatic test_random_frames();
      int target;
      int wsel;
      int hsel;
      int cut;
      target = pixels_sent + 1450;
      while (pixels_sent < target) begin
         pix_mode = pix_mode_type'($urandom_range(0, 4));
         steady_sender = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: wsel = $urandom_range(0, 2);
               1: wsel = $urandom_range(17, 40);
               default: wsel = $urandom_range(3, 16);
            endcase
            hsel = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            set_regs(1'b1, {5'($urandom), 11'(wsel)}, 1'b1, 16'(hsel));
         end
         if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, width_in_use() * height_in_use() - 1);
            repeat (cut) send_pixel(next_pixel());
            if ($urandom_range(0, 1))
               set_regs(1'b0, '0, 1'b1, 16'($urandom_range(0, 8)));
            else
               set_regs(1'b1, {5'($urandom), 11'($urandom_range(0, width_in_use()))},
                        1'b0, '0);
         end
         run_to_frame_end();
      end
   endtask

   // Result side: random stalls, compare each word with the oldest expectation
   always @(posedge clock) begin : check_means
      mean_word_type want;
      int            stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            errors++;
            $error("unexpected result word: mean_value %0d, last_of_frame %0d",
                   rsp_mean_value, rsp_last_of_frame);
         end else begin
            want = expected_means.pop_front();
            if (rsp_mean_value !== want.mean) begin
               errors++;
               $error("mean_value: expected %0d, actual %0d", want.mean, rsp_mean_value);
            end
            if (rsp_last_of_frame !== want.last) begin
               errors++;
               $error("last_of_frame: expected %0d, actual %0d", want.last,
                      rsp_last_of_frame);
            end
         end
         if ($urandom_range(0, 39) == 0) steady_receiver = !steady_receiver;
         stall = steady_receiver ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= stall - 1;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold == 0) rsp_ready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   initial begin
      foreach (upper_row[k]) upper_row[k] = '0;
      foreach (middle_row[k]) middle_row[k] = '0;
      foreach (window_px[k]) window_px[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extreme_pixels();
      test_widest_frame();
      test_mid_frame_changes();
      test_random_frames();
      settle();
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bf3m_pkg.sv
rtl/bf3m_ram.sv
rtl/box_filter_3x3_mean.sv
test/tb_box_filter_3x3_mean.sv
